// File: sv/i2c_bus_clear_sequencer_core_defines.svh
// assertion macros used by the bus-clear sequencer rtl
`ifndef I2C_BUS_CLEAR_SEQUENCER_CORE_DEFINES_SVH
`define I2C_BUS_CLEAR_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define I2CBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("i2cbc assertion failed");

`define I2CBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("i2cbc assertion failed");

`else

`define I2CBC_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define I2CBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: sv/i2cbc_pkg.sv
// types and constants of the bus-clear sequencer
package i2cbc_pkg;

	localparam int CNT_W       = 4;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CNT_W-1:0] MAX_CLOCKS_RST = CNT_W'(9);

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef enum logic [1:0] {
		OUT_OK      = 2'd0,
		OUT_TIMEOUT = 2'd1,
		OUT_BUSY    = 2'd2
	} outcome_t;

	typedef struct packed {
		logic             scl_pull_low;
		logic             sda_pull_low;
		logic             running;
		logic             finished;
		outcome_t         outcome;
		logic [CNT_W-1:0] clocks_sent;
	} res_t;

endpackage

// File: sv/i2cbc_fsm.sv
// recovery sequence state machine: one word in, next state and result out
`include "i2c_bus_clear_sequencer_core_defines.svh"

module i2cbc_fsm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      kind,
	input  logic                      scl_level,
	input  logic                      sda_level,
	input  logic [i2cbc_pkg::CNT_W-1:0] max_clocks,
	output i2cbc_pkg::res_t           res
);
	import i2cbc_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_SETTLE   = 3'd1,
		PH_CLK_LOW  = 3'd2,
		PH_CLK_HIGH = 3'd3,
		PH_EDGE_A   = 3'd4,
		PH_EDGE_B   = 3'd5,
		PH_SAMPLE   = 3'd6
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] pulse_q, pulse_d;
	logic             scl_q, scl_d;
	logic             sda_q, sda_d;
	logic             done;
	outcome_t         outc;

	always_comb begin
		phase_d = phase_q;
		pulse_d = pulse_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		done    = 1'b0;
		outc    = OUT_OK;
		if (kind == KIND_START) begin
			scl_d   = 1'b0;
			sda_d   = 1'b0;
			pulse_d = '0;
			phase_d = PH_SETTLE;
		end else begin
			unique case (phase_q) inside
				PH_SETTLE, PH_CLK_HIGH: begin
					if (phase_q == PH_CLK_HIGH) begin
						pulse_d = pulse_q + CNT_W'(1);
					end
					// check point: stuck clock, another pulse, or start/stop
					if (!scl_level) begin
						scl_d   = 1'b0;
						sda_d   = 1'b0;
						phase_d = PH_IDLE;
						outc    = OUT_TIMEOUT;
						done    = 1'b1;
					end else if (!sda_level && (pulse_d < max_clocks)) begin
						scl_d   = 1'b1;
						phase_d = PH_CLK_LOW;
					end else begin
						sda_d   = 1'b1;
						phase_d = PH_EDGE_A;
					end
				end
				PH_CLK_LOW: begin
					scl_d   = 1'b0;
					phase_d = PH_CLK_HIGH;
				end
				PH_EDGE_A: begin
					scl_d   = 1'b0;
					phase_d = PH_EDGE_B;
				end
				PH_EDGE_B: begin
					sda_d   = 1'b0;
					phase_d = PH_SAMPLE;
				end
				PH_SAMPLE: begin
					outc    = (!scl_level || !sda_level) ? OUT_BUSY : OUT_OK;
					scl_d   = 1'b0;
					sda_d   = 1'b0;
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
				default: begin
					// idle tick: lines stay released, count holds
					phase_d = PH_IDLE;
					scl_d   = 1'b0;
					sda_d   = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pulse_q <= '0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			pulse_q <= pulse_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
		end
	end

	always_comb begin
		res.scl_pull_low = scl_d;
		res.sda_pull_low = sda_d;
		res.running      = (phase_d != PH_IDLE);
		res.finished     = done;
		res.outcome      = done ? outc : OUT_OK;
		res.clocks_sent  = pulse_d;
	end

	`I2CBC_ASSERT_IMP(a_fin_not_running, clk, arst_n, en && res.finished, !res.running)
	`I2CBC_ASSERT_IMP(a_outcome_only_fin, clk, arst_n, en && (res.outcome != OUT_OK), res.finished)
	`I2CBC_ASSERT_NEXT(a_start_clears, clk, arst_n, en && (kind == KIND_START),
		(phase_q == PH_SETTLE) && (pulse_q == '0) && !scl_q && !sda_q)
	`I2CBC_ASSERT_IMP(a_idle_released, clk, arst_n, phase_q == PH_IDLE, !scl_q && !sda_q)

endmodule

// File: sv/i2c_bus_clear_sequencer_core.sv
// top level of the i2c bus-clear sequencer
//
//  group   dir  tdata (low bit up)                                 side bits
//  s_axis  in   scl_level, sda_level, pad                          tuser = kind
//  m_axis  out  scl_pull_low, sda_pull_low, running, outcome,      tlast = finished
//               clocks_sent, pad
//  cfg     in   cfg_wr_data = max_clocks                           cfg_wr_en
//
// one word per cycle sustained while the output is not stalled
// an input register feeds the state machine, its result lands in the output register
// the state machine advances on a held input word when that register is empty or being drained
// reset clears all control state and loads max_clocks with nine; no clearing pass
// a stalled output holds its word and backs up into the input register

module i2c_bus_clear_sequencer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [i2cbc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // scl_level, sda_level
	input  logic                                s_axis_tuser,   // kind
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [i2cbc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // scl, sda, running, outcome, clocks
	output logic                                m_axis_tlast,   // finished
	input  logic                                cfg_wr_en,
	input  logic [i2cbc_pkg::CNT_W-1:0]         cfg_wr_data
);
	import i2cbc_pkg::*;

	logic             valid_s1;
	logic             kind_s1;
	logic             scl_s1;
	logic             sda_s1;
	logic             out_valid_q;
	res_t             out_q;
	res_t             res;
	logic [CNT_W-1:0] max_clocks_q;
	logic             advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_clocks_q <= MAX_CLOCKS_RST;
		end else if (cfg_wr_en) begin
			max_clocks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser;
			scl_s1  <= s_axis_tdata[0];
			sda_s1  <= s_axis_tdata[1];
		end
	end

	i2cbc_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.kind       (kind_s1),
		.scl_level  (scl_s1),
		.sda_level  (sda_s1),
		.max_clocks (max_clocks_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.finished;
	assign m_axis_tdata  = {7'b0, out_q.clocks_sent, out_q.outcome, out_q.running,
		out_q.sda_pull_low, out_q.scl_pull_low};

endmodule
